// ===== rtl/core/rpcs_pkg.sv =====
package rpcs_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 15;

   localparam logic [CsrIndexWidth-1:0] CSR_TURN_SPEED     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FALL_THRESHOLD = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_RISE_MARGIN    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SWEEP_LIMIT    = 2'd3;

   localparam logic [2:0] STATUS_WAIT  = 3'd0;
   localparam logic [2:0] STATUS_SCAN  = 3'd1;
   localparam logic [2:0] STATUS_TURN  = 3'd2;
   localparam logic [2:0] STATUS_LOCK  = 3'd3;
   localparam logic [2:0] STATUS_NONE  = 3'd4;

   typedef struct packed {
      logic              button_touched;
      logic signed [15:0] heading;
      logic [6:0]        reflection;
   } req_word_type;

   typedef struct packed {
      logic signed [7:0]  left_speed;
      logic signed [7:0]  right_speed;
      logic               zero_heading;
      logic [2:0]         status;
      logic signed [15:0] rise_heading;
      logic signed [15:0] center_heading;
   } rsp_word_type;

   typedef struct packed {
      logic [6:0]  turn_speed;
      logic [6:0]  fall_threshold;
      logic [6:0]  rise_margin;
      logic [14:0] sweep_limit;
   } cfg_type;

   typedef enum logic [4:0] {
      MODE_WAIT = 5'b00001,
      MODE_SCAN = 5'b00010,
      MODE_TURN = 5'b00100,
      MODE_LOCK = 5'b01000,
      MODE_NONE = 5'b10000
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic               edge_phase;
      logic [6:0]         background_min;
      logic [6:0]         peak_level;
      logic signed [15:0] rise_angle;
      logic signed [15:0] center_angle;
      logic               sweep_reversed;
      logic               turn_left;
   } scan_state_type;

   localparam cfg_type CFG_RESET = '{
      turn_speed:     7'd30,
      fall_threshold: 7'd1,
      rise_margin:    7'd2,
      sweep_limit:    15'd6000
   };

   localparam scan_state_type STATE_RESET = '{
      mode:           MODE_WAIT,
      edge_phase:     1'b0,
      background_min: 7'd0,
      peak_level:     7'd0,
      rise_angle:     16'sd0,
      center_angle:   16'sd0,
      sweep_reversed: 1'b0,
      turn_left:      1'b0
   };

   function automatic logic [2:0] mode_status(mode_type mode);
      logic [2:0] code;
      unique case (mode)
         MODE_WAIT: code = STATUS_WAIT;
         MODE_SCAN: code = STATUS_SCAN;
         MODE_TURN: code = STATUS_TURN;
         MODE_LOCK: code = STATUS_LOCK;
         MODE_NONE: code = STATUS_NONE;
         default:   code = STATUS_WAIT;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/rpcs_csr.sv =====
module rpcs_csr
   import rpcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     write_enable,
   input  logic [CsrIndexWidth-1:0] index,
   input  logic [CsrDataWidth-1:0]  data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (write_enable) begin
         unique case (index)
            CSR_TURN_SPEED:     cfg_ff.turn_speed     <= data[6:0];
            CSR_FALL_THRESHOLD: cfg_ff.fall_threshold <= data[6:0];
            CSR_RISE_MARGIN:    cfg_ff.rise_margin    <= data[6:0];
            CSR_SWEEP_LIMIT:    cfg_ff.sweep_limit    <= data[14:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/rpcs_step.sv =====
module rpcs_step
   import rpcs_pkg::*;
(
   input  scan_state_type state,
   input  req_word_type   word,
   input  cfg_type        cfg,
   output scan_state_type state_in,
   output rsp_word_type   result
);

   always_comb begin
      logic signed [16:0] head_x;
      logic signed [16:0] lim_x;
      logic signed [16:0] neg_lim_x;
      logic signed [16:0] sum;
      logic signed [15:0] target;
      logic [7:0]         rise_level;
      logic [6:0]         drop;
      logic signed [7:0]  ts_pos;
      logic signed [7:0]  ts_neg;
      logic signed [7:0]  left;
      logic               fell;
      logic               zero;

      head_x     = 17'(word.heading);
      lim_x      = $signed({2'b00, cfg.sweep_limit});
      neg_lim_x  = -lim_x;
      sum        = 17'(state.rise_angle) + head_x;
      target     = sum[16:1];
      rise_level = {1'b0, state.background_min} + {1'b0, cfg.rise_margin};
      drop       = state.peak_level - word.reflection;
      ts_pos     = $signed({1'b0, cfg.turn_speed});
      ts_neg     = -ts_pos;
      state_in   = state;
      fell       = 1'b0;
      zero       = 1'b0;
      left       = '0;

      unique case (state.mode)
         MODE_SCAN: begin
            if (!state.edge_phase) begin
               if ({1'b0, word.reflection} > rise_level) begin
                  state_in.rise_angle = word.heading;
                  state_in.edge_phase = 1'b1;
                  state_in.peak_level = word.reflection;
               end else if (word.reflection < state.background_min) begin
                  state_in.background_min = word.reflection;
               end
            end else begin
               if (word.reflection > state.peak_level) begin
                  state_in.peak_level = word.reflection;
               end else if (drop >= cfg.fall_threshold) begin
                  fell = 1'b1;
                  state_in.center_angle = target;
               end
            end
            priority if (fell) begin
               if (word.heading > target) begin
                  state_in.turn_left = 1'b1;
                  state_in.mode      = MODE_TURN;
               end else if (word.heading < target) begin
                  state_in.turn_left = 1'b0;
                  state_in.mode      = MODE_TURN;
               end else begin
                  state_in.mode = MODE_LOCK;
               end
            end else if (head_x >= lim_x) begin
               state_in.sweep_reversed = 1'b1;
            end else if (head_x <= neg_lim_x) begin
               state_in.mode = MODE_NONE;
            end else begin
               state_in.mode = MODE_SCAN;
            end
            if (state_in.mode == MODE_SCAN) begin
               left = state_in.sweep_reversed ? ts_neg : ts_pos;
            end
         end
         MODE_TURN: begin
            if (state.turn_left ? (word.heading <= state.center_angle)
                                : (word.heading >= state.center_angle)) begin
               state_in.mode = MODE_LOCK;
            end
         end
         MODE_WAIT, MODE_LOCK, MODE_NONE: begin
            if (word.button_touched) begin
               state_in.mode           = MODE_SCAN;
               state_in.edge_phase     = 1'b0;
               state_in.background_min = word.reflection;
               state_in.sweep_reversed = 1'b0;
               zero                    = 1'b1;
               left                    = ts_pos;
            end
         end
         default: begin
            state_in.mode = MODE_WAIT;
         end
      endcase

      if (state_in.mode == MODE_TURN) begin
         left = state_in.turn_left ? ts_neg : ts_pos;
      end

      result.left_speed     = left;
      result.right_speed    = -left;
      result.zero_heading   = zero;
      result.status         = mode_status(state_in.mode);
      result.rise_heading   = state_in.rise_angle;
      result.center_heading = state_in.center_angle;
   end

endmodule

// ===== rtl/core/reflection_peak_centering_scan.sv =====
// Channel  Direction  Ports                          Word
// req      in         req_valid req_stall req_word   button, heading, reflection
// rsp      out        rsp_valid rsp_stall rsp_word   speeds, zero pulse, status, headings
// csr      in         csr_write_enable csr_index csr_data
//
// One word per cycle sustained while rsp_stall is low; rsp_valid rises once the accepted word
// has gone through the input register, then the scan step into the result register.
// Synchronous active-high reset clears the valids and returns the scan state and the CSRs to their reset values.
// A stalled rsp holds the result register; req stalls only when a word sits in
// the input register and the result register cannot take it.
module reflection_peak_centering_scan
   import rpcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_word,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type        cfg;
   logic           in_valid_ff;
   req_word_type   in_word_ff;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_word_ff;
   rsp_word_type   rsp_word_in;
   scan_state_type state_ff;
   scan_state_type state_in;
   logic           out_open;
   logic           advance;

   rpcs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .data         (csr_data),
      .cfg          (cfg)
   );

   rpcs_step u_step (
      .state    (state_ff),
      .word     (in_word_ff),
      .cfg      (cfg),
      .state_in (state_in),
      .result   (rsp_word_in)
   );

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_idle_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.status == STATUS_WAIT ||
                       rsp_word_ff.status == STATUS_LOCK ||
                       rsp_word_ff.status == STATUS_NONE)
      |-> rsp_word_ff.left_speed == 8'sd0)
      else $error("wheels commanded while not scanning or turning");

   a_zero_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.zero_heading |-> rsp_word_ff.status == STATUS_SCAN)
      else $error("heading zero pulse outside scan start");

   a_spin_in_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.right_speed == -rsp_word_ff.left_speed)
      else $error("wheel speeds not opposite");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("scan state changed without a word");

endmodule

// ===== tb/reflection_peak_centering_scan_tb.sv =====
module reflection_peak_centering_scan_tb
   import rpcs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 300000;
   localparam int PhaseWords = 80;

   class peak_scan_tracker;
      cfg_type          settings;
      logic [2:0]       mode;
      bit               rising_seen;
      int               floor_level;
      int               peak_level;
      int               rise_angle;
      int               center_angle;
      bit               sweep_left;
      bit               turn_left;
      rsp_word_type     pending_commands[$];
      int               mismatches;

      function new();
         settings     = CFG_RESET;
         mode         = STATUS_WAIT;
         rising_seen  = 0;
         floor_level  = 0;
         peak_level   = 0;
         rise_angle   = 0;
         center_angle = 0;
         sweep_left   = 0;
         turn_left    = 0;
         mismatches   = 0;
      endfunction

      // one sensor word in, the wheel command it produces queued and returned
      function rsp_word_type take_tick(req_word_type w);
         int           head;
         int           refl;
         int           ts;
         int           speed;
         bit           fell;
         rsp_word_type cmd;
         head = w.heading;
         refl = w.reflection;
         ts   = settings.turn_speed;
         fell = 0;
         cmd  = '0;
         if (mode == STATUS_SCAN) begin
            if (!rising_seen) begin
               if (refl > floor_level + int'(settings.rise_margin)) begin
                  rise_angle  = head;
                  rising_seen = 1;
                  peak_level  = refl;
               end else if (refl < floor_level) begin
                  floor_level = refl;
               end
            end else if (refl > peak_level) begin
               peak_level = refl;
            end else if (peak_level - refl >= int'(settings.fall_threshold)) begin
               fell         = 1;
               center_angle = (rise_angle + head) >>> 1;
            end
            if (fell) begin
               if (head == center_angle) begin
                  mode = STATUS_LOCK;
               end else begin
                  turn_left = head > center_angle;
                  mode      = STATUS_TURN;
               end
            end else if (head >= int'(settings.sweep_limit)) begin
               sweep_left = 1;
            end else if (head <= -int'(settings.sweep_limit)) begin
               mode = STATUS_NONE;
            end
         end else if (mode == STATUS_TURN) begin
            if (turn_left ? (head <= center_angle) : (head >= center_angle))
               mode = STATUS_LOCK;
         end else if (w.button_touched) begin
            mode             = STATUS_SCAN;
            cmd.zero_heading = 1'b1;
            rising_seen      = 0;
            floor_level      = refl;
            sweep_left       = 0;
         end
         speed = 0;
         if (mode == STATUS_SCAN)
            speed = sweep_left ? -ts : ts;
         else if (mode == STATUS_TURN)
            speed = turn_left ? -ts : ts;
         cmd.left_speed     = 8'(speed);
         cmd.right_speed    = 8'(-speed);
         cmd.status         = mode;
         cmd.rise_heading   = 16'(rise_angle);
         cmd.center_heading = 16'(center_angle);
         pending_commands.push_back(cmd);
         return cmd;
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_command(rsp_word_type got);
         rsp_word_type want;
         if (pending_commands.size() == 0) begin
            $error("command word arrived with none expected");
            mismatches++;
            return;
         end
         want = pending_commands.pop_front();
         compare_field("left_speed", want.left_speed, got.left_speed);
         compare_field("right_speed", want.right_speed, got.right_speed);
         compare_field("zero_heading", want.zero_heading, got.zero_heading);
         compare_field("status", want.status, got.status);
         compare_field("rise_heading", want.rise_heading, got.rise_heading);
         compare_field("center_heading", want.center_heading, got.center_heading);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_word_type             req_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_word_type             rsp_word;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_TURN_SPEED;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   peak_scan_tracker tracker;
   rsp_word_type     last_cmd;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               cycle_count = 0;
   int               robot_heading = 0;
   int               base_level = 10;
   int               bump_height = 30;
   int               bump_lo = 0;
   int               bump_hi = 0;
   cfg_type          phase_cfg;

   reflection_peak_centering_scan dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_command(rsp_word);
         rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
      end
   end

   task automatic send_word(req_word_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      last_cmd = tracker.take_tick(w);
      if (last_cmd.zero_heading)
         robot_heading = 0;
   endtask

   task automatic tick(bit press, int head, int refl);
      req_word_type w;
      w.button_touched = press;
      w.heading        = 16'(head);
      w.reflection     = 7'(refl);
      send_word(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_commands.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(cfg_type c);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TURN_SPEED;
      csr_data         <= 15'(c.turn_speed);
      @(posedge clock);
      csr_index        <= CSR_FALL_THRESHOLD;
      csr_data         <= 15'(c.fall_threshold);
      @(posedge clock);
      csr_index        <= CSR_RISE_MARGIN;
      csr_data         <= 15'(c.rise_margin);
      @(posedge clock);
      csr_index        <= CSR_SWEEP_LIMIT;
      csr_data         <= c.sweep_limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      tracker.settings = c;
   endtask

   // robot model: heading mostly follows the command, reflection has one stripe
   function automatic req_word_type next_tick();
      req_word_type w;
      int           lim;
      int           lvl;
      int           dir;
      lim = tracker.settings.sweep_limit;
      w   = '0;
      if ($urandom_range(99) < 8) begin
         w.button_touched = 1'($urandom_range(1));
         w.heading        = 16'(int'($urandom_range(36000)) - 18000);
         w.reflection     = 7'($urandom_range(100));
         return w;
      end
      if (tracker.mode == STATUS_SCAN || tracker.mode == STATUS_TURN) begin
         if (tracker.mode == STATUS_SCAN)
            dir = tracker.sweep_left ? -1 : 1;
         else
            dir = tracker.turn_left ? -1 : 1;
         if ($urandom_range(9) == 0)
            dir = -dir;
         robot_heading += dir * int'($urandom_range(lim / 10 + 1, 1));
         if (robot_heading > 18000)
            robot_heading = 18000;
         if (robot_heading < -18000)
            robot_heading = -18000;
         w.button_touched = $urandom_range(9) == 0;
         w.heading        = 16'(robot_heading);
      end else begin
         base_level       = $urandom_range(40);
         bump_height      = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(60));
         bump_lo          = int'($urandom_range(2 * lim)) - lim;
         bump_hi          = bump_lo + int'($urandom_range(lim / 2 + 1));
         w.button_touched = $urandom_range(2) == 0;
         w.heading        = 16'(int'($urandom_range(36000)) - 18000);
      end
      lvl = base_level;
      if (robot_heading >= bump_lo && robot_heading <= bump_hi)
         lvl += bump_height;
      if ($urandom_range(3) == 0)
         lvl += int'($urandom_range(4)) - 2;
      if (lvl < 0)
         lvl = 0;
      if (lvl > 100)
         lvl = 100;
      w.reflection = 7'(lvl);
      return w;
   endfunction

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset settings
      tick(0, 18000, 100);
      tick(0, -18000, 0);
      tick(1, -1, 10);
      tick(1, 100, 10);
      tick(0, 200, 5);
      tick(0, 300, 8);
      tick(0, 400, 50);
      tick(0, 6000, 50);
      tick(0, 5000, 49);
      tick(1, 4000, 0);
      tick(0, 2650, 0);
      tick(0, 2000, 0);
      tick(1, 123, 100);
      tick(0, 0, 100);
      tick(0, -6000, 0);
      tick(0, 0, 0);
      tick(1, 0, 0);
      tick(0, -3, 3);
      tick(0, -2, 2);
      tick(0, -3, 0);
      tick(1, 0, 0);
      tick(0, -5, 3);
      tick(0, -5, 2);
      tick(1, 0, 0);
      tick(0, 10, 3);
      tick(0, 5, 0);
      tick(0, 7, 0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: phase_cfg = '{turn_speed: 7'd100, fall_threshold: 7'd0,
                             rise_margin: 7'd0, sweep_limit: 15'd1000};
            1: phase_cfg = '{turn_speed: 7'd0, fall_threshold: 7'd100,
                             rise_margin: 7'd100, sweep_limit: 15'd0};
            2: phase_cfg = '{turn_speed: 7'($urandom_range(100, 1)),
                             fall_threshold: 7'($urandom_range(10, 1)),
                             rise_margin: 7'($urandom_range(20)),
                             sweep_limit: 15'd18000};
            3: phase_cfg = '{turn_speed: 7'($urandom_range(100)),
                             fall_threshold: 7'($urandom_range(5)),
                             rise_margin: 7'($urandom_range(10)),
                             sweep_limit: 15'($urandom_range(3000, 200))};
            4: phase_cfg = '{turn_speed: 7'd1, fall_threshold: 7'd1,
                             rise_margin: 7'd1, sweep_limit: 15'd1};
            default: phase_cfg = CFG_RESET;
         endcase
         load_settings(phase_cfg);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 85;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 85;
            end
            default: begin
               send_idle_pct = 11;
               stall_pct     = 11;
            end
         endcase
         repeat (PhaseWords) send_word(next_tick());
      end

      drain();
      if (tracker.mismatches == 0 && tracker.pending_commands.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
